@@ rtl/core/twrtc_pkg.sv @@
// Shared types, codes and constants for the three-wire serial clock master.
// No dependencies; compiled first.
package twrtc_pkg;

   typedef enum logic [2:0] {
      MODE_TICK  = 3'd0,
      MODE_WRITE = 3'd1,
      MODE_READ  = 3'd2,
      MODE_SET   = 3'd3,
      MODE_GET   = 3'd4
   } mode_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_LOW   = 5'b00100,
      PH_HIGH  = 5'b01000,
      PH_END   = 5'b10000
   } phase_type;

   localparam int unsigned TIME_FIELDS = 7;

   localparam logic [7:0] WP_ADDR      = 8'h8E;
   localparam logic [7:0] TIME_WR_BASE = 8'h80;
   localparam logic [7:0] TIME_RD_BASE = 8'h81;
   localparam logic [7:0] WP_CLEAR     = 8'h00;
   localparam logic [7:0] WP_SET       = 8'h80;

   localparam logic [3:0] SET_FRAMES    = 4'd9;
   localparam logic [3:0] GET_FRAMES    = 4'd7;
   localparam logic [3:0] SINGLE_FRAMES = 4'd1;
   localparam logic [3:0] LAST_BIT      = 4'd15;

   localparam logic [2:0] SINGLE_READ_INDEX = 3'd7;

   // BCD byte to binary, each nibble taken as unsigned (0..165)
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'b0000, b[7:4]} * 8'd10;
      return tens + {4'b0000, b[3:0]};
   endfunction

endpackage

@@ rtl/core/twrtc_if.sv @@
// Valid/ready channel interfaces for command/tick transactions and results.
// Depends on nothing; compiled after twrtc_pkg.
interface twrtc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       data_in;
   logic [7:0] address;
   logic [7:0] write_value;
   logic [7:0] set_seconds;
   logic [7:0] set_minutes;
   logic [7:0] set_hours;
   logic [7:0] set_date;
   logic [7:0] set_month;
   logic [7:0] set_weekday;
   logic [7:0] set_year;

   modport source (
      output valid, mode, data_in, address, write_value, set_seconds, set_minutes,
             set_hours, set_date, set_month, set_weekday, set_year,
      input  ready
   );
   modport sink (
      input  valid, mode, data_in, address, write_value, set_seconds, set_minutes,
             set_hours, set_date, set_month, set_weekday, set_year,
      output ready
   );
endinterface

interface twrtc_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_enable;
   logic       serial_clock;
   logic       data_out;
   logic       data_drive;
   logic       busy_res;
   logic       value_valid;
   logic [2:0] value_index;
   logic [7:0] read_value;
   logic       done_res;

   modport source (
      output valid, chip_enable, serial_clock, data_out, data_drive, busy_res,
             value_valid, value_index, read_value, done_res,
      input  ready
   );
   modport sink (
      input  valid, chip_enable, serial_clock, data_out, data_drive, busy_res,
             value_valid, value_index, read_value, done_res,
      output ready
   );
endinterface

@@ rtl/core/twrtc_frame_src.sv @@
// Operand store and per-frame address/data byte selection.
// Depends on twrtc_pkg.
module twrtc_frame_src (
   input  logic                 clock,
   input  logic                 load,
   input  logic [7:0]           load_address,
   input  logic [7:0]           load_value,
   input  logic [7:0]           load_time [twrtc_pkg::TIME_FIELDS],
   input  twrtc_pkg::mode_type  command,
   input  logic [3:0]           transfer_index,
   output logic [7:0]           frame_addr,
   output logic [7:0]           frame_data
);

   logic [7:0] single_addr_ff;
   logic [7:0] single_val_ff;
   logic [7:0] time_bytes_ff [twrtc_pkg::TIME_FIELDS];
   logic [3:0] index_m1;

   always_ff @(posedge clock) begin
      if (load) begin
         single_addr_ff <= load_address;
         single_val_ff  <= load_value;
         time_bytes_ff  <= load_time;
      end
   end

   assign index_m1 = transfer_index - 4'd1;

   always_comb begin
      frame_addr = single_addr_ff;
      frame_data = single_val_ff;
      case (command)
         twrtc_pkg::MODE_SET: begin
            // frame 0 clears write protect, last frame sets it
            if (transfer_index == 4'd0) begin
               frame_addr = twrtc_pkg::WP_ADDR;
               frame_data = twrtc_pkg::WP_CLEAR;
            end else if (transfer_index >= 4'd8) begin
               frame_addr = twrtc_pkg::WP_ADDR;
               frame_data = twrtc_pkg::WP_SET;
            end else begin
               frame_addr = twrtc_pkg::TIME_WR_BASE + {3'b000, index_m1, 1'b0};
               frame_data = time_bytes_ff[index_m1[2:0]];
            end
         end
         twrtc_pkg::MODE_GET: begin
            frame_addr = twrtc_pkg::TIME_RD_BASE + {4'b0000, transfer_index[2:0], 1'b0};
         end
         default: begin
            frame_addr = single_addr_ff;
            frame_data = single_val_ff;
         end
      endcase
   end

endmodule

@@ rtl/core/three_wire_rtc_serial_master_unit.sv @@
// Top level of the three-wire serial clock master: handshake, bus sequencer,
// result register. Depends on twrtc_pkg, twrtc_if and twrtc_frame_src.
//
// Pin-level master for a three-wire serial clock chip (CE, SCLK, DATA).
// While idle, a transaction with mode 1..4 starts a command (write register,
// read register, set the seven time registers, get the seven time registers);
// every later transaction is one tick, i.e. one half SCLK period, and any
// command issued while busy counts as a plain tick. Each transaction yields
// exactly one result transaction carrying the pin levels to drive for that
// half period, plus busy, done and any finished read byte. A frame is: start
// tick (CE up), 16 bits of two ticks each (low half sets/releases data, high
// half raises SCLK and samples data_in on read bits), end tick (CE down). Set
// time runs 9 frames (write-protect off, seven bytes at 0x80..0x8C, protect
// on); get time runs 7 frames reading 0x81..0x8D and returns each byte
// BCD-decoded as unsigned. Throughput is one transaction per clock while the sink
// keeps up: each step is computed from the accepted transaction straight into the result
// register, and req.ready stays high unless a result is held by a stalled sink.
module three_wire_rtc_serial_master_unit (
   input  logic           clock,
   input  logic           reset,
   twrtc_req_if.sink      req_chan,
   twrtc_rsp_if.source    rsp_chan
);

   // sequencer state
   twrtc_pkg::phase_type phase_ff, phase_in;
   twrtc_pkg::mode_type  command_ff, command_in;
   logic [3:0]           bit_count_ff, bit_count_in;
   logic [7:0]           shift_byte_ff, shift_byte_in;
   logic [3:0]           transfer_ff, transfer_in;
   logic                 ce_ff, ce_in;
   logic                 sclk_ff, sclk_in;
   logic                 dout_ff, dout_in;
   logic                 drive_ff, drive_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 value_valid_ff, value_valid_in;
   logic [2:0]           value_index_ff, value_index_in;
   logic [7:0]           read_value_ff, read_value_in;
   logic                 done_ff, done_in;
   logic                 busy_ff;

   logic                 fire;
   logic                 start_cmd;
   twrtc_pkg::phase_type phase_eff;
   twrtc_pkg::mode_type  command_eff;
   logic                 frame_reads;
   logic [3:0]           frame_total;
   logic [7:0]           frame_addr;
   logic [7:0]           frame_data;
   logic [7:0]           tx_byte;
   logic [7:0]           load_time [twrtc_pkg::TIME_FIELDS];

   // a result slot frees as soon as the sink takes the held one
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;

   assign start_cmd = (phase_ff == twrtc_pkg::PH_IDLE) &&
                      (req_chan.mode inside {[twrtc_pkg::MODE_WRITE:twrtc_pkg::MODE_GET]});

   assign load_time[0] = req_chan.set_seconds;
   assign load_time[1] = req_chan.set_minutes;
   assign load_time[2] = req_chan.set_hours;
   assign load_time[3] = req_chan.set_date;
   assign load_time[4] = req_chan.set_month;
   assign load_time[5] = req_chan.set_weekday;
   assign load_time[6] = req_chan.set_year;

   twrtc_frame_src u_frame_src (
      .clock          (clock),
      .load           (fire && start_cmd),
      .load_address   (req_chan.address),
      .load_value     (req_chan.write_value),
      .load_time      (load_time),
      .command        (command_ff),
      .transfer_index (transfer_ff),
      .frame_addr     (frame_addr),
      .frame_data     (frame_data)
   );

   // the command transaction itself is the first frame's start tick
   assign phase_eff   = start_cmd ? twrtc_pkg::PH_START : phase_ff;
   assign command_eff = start_cmd ? twrtc_pkg::mode_type'(req_chan.mode) : command_ff;
   assign frame_reads = (command_eff == twrtc_pkg::MODE_READ) ||
                        (command_eff == twrtc_pkg::MODE_GET);

   always_comb begin
      case (command_eff)
         twrtc_pkg::MODE_SET: frame_total = twrtc_pkg::SET_FRAMES;
         twrtc_pkg::MODE_GET: frame_total = twrtc_pkg::GET_FRAMES;
         default:             frame_total = twrtc_pkg::SINGLE_FRAMES;
      endcase
   end

   assign tx_byte = bit_count_ff[3] ? frame_data : frame_addr;

   always_comb begin
      phase_in       = phase_eff;
      command_in     = command_eff;
      bit_count_in   = bit_count_ff;
      shift_byte_in  = shift_byte_ff;
      transfer_in    = start_cmd ? 4'd0 : transfer_ff;
      ce_in          = ce_ff;
      sclk_in        = sclk_ff;
      dout_in        = dout_ff;
      drive_in       = drive_ff;
      value_valid_in = 1'b0;
      value_index_in = 3'd0;
      read_value_in  = 8'd0;
      done_in        = 1'b0;
      case (phase_eff)
         twrtc_pkg::PH_START: begin
            ce_in         = 1'b1;
            sclk_in       = 1'b0;
            dout_in       = 1'b0;
            drive_in      = 1'b1;
            bit_count_in  = 4'd0;
            shift_byte_in = 8'd0;
            phase_in      = twrtc_pkg::PH_LOW;
         end
         twrtc_pkg::PH_LOW: begin
            sclk_in = 1'b0;
            if (bit_count_ff[3] && frame_reads) begin
               // release the line for the chip's data byte
               drive_in = 1'b0;
               dout_in  = 1'b0;
            end else begin
               drive_in = 1'b1;
               dout_in  = tx_byte[bit_count_ff[2:0]];
            end
            phase_in = twrtc_pkg::PH_HIGH;
         end
         twrtc_pkg::PH_HIGH: begin
            if (bit_count_ff[3] && frame_reads) begin
               shift_byte_in = {req_chan.data_in, shift_byte_ff[7:1]};
            end
            sclk_in = 1'b1;
            if (bit_count_ff == twrtc_pkg::LAST_BIT) begin
               phase_in = twrtc_pkg::PH_END;
            end else begin
               bit_count_in = bit_count_ff + 4'd1;
               phase_in     = twrtc_pkg::PH_LOW;
            end
         end
         twrtc_pkg::PH_END: begin
            ce_in    = 1'b0;
            sclk_in  = 1'b0;
            dout_in  = 1'b0;
            drive_in = 1'b1;
            if (frame_reads) begin
               value_valid_in = 1'b1;
               if (command_eff == twrtc_pkg::MODE_GET) begin
                  value_index_in = transfer_ff[2:0];
                  read_value_in  = twrtc_pkg::bcd_to_bin(shift_byte_ff);
               end else begin
                  value_index_in = twrtc_pkg::SINGLE_READ_INDEX;
                  read_value_in  = shift_byte_ff;
               end
            end
            transfer_in = transfer_ff + 4'd1;
            if (transfer_in >= frame_total) begin
               phase_in   = twrtc_pkg::PH_IDLE;
               done_in    = 1'b1;
               command_in = twrtc_pkg::MODE_TICK;
            end else begin
               phase_in = twrtc_pkg::PH_START;
            end
         end
         default: begin
            phase_in = twrtc_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= twrtc_pkg::PH_IDLE;
         command_ff    <= twrtc_pkg::MODE_TICK;
         bit_count_ff  <= 4'd0;
         shift_byte_ff <= 8'd0;
         transfer_ff   <= 4'd0;
         ce_ff         <= 1'b0;
         sclk_ff       <= 1'b0;
         dout_ff       <= 1'b0;
         drive_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            command_ff    <= command_in;
            bit_count_ff  <= bit_count_in;
            shift_byte_ff <= shift_byte_in;
            transfer_ff   <= transfer_in;
            ce_ff         <= ce_in;
            sclk_ff       <= sclk_in;
            dout_ff       <= dout_in;
            drive_ff      <= drive_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // result payload, pins come straight from the pin state
   always_ff @(posedge clock) begin
      if (fire) begin
         value_valid_ff <= value_valid_in;
         value_index_ff <= value_index_in;
         read_value_ff  <= read_value_in;
         done_ff        <= done_in;
         busy_ff        <= (phase_in != twrtc_pkg::PH_IDLE);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.chip_enable  = ce_ff;
   assign rsp_chan.serial_clock = sclk_ff;
   assign rsp_chan.data_out     = dout_ff;
   assign rsp_chan.data_drive   = drive_ff;
   assign rsp_chan.busy_res     = busy_ff;
   assign rsp_chan.value_valid  = value_valid_ff;
   assign rsp_chan.value_index  = value_index_ff;
   assign rsp_chan.read_value   = read_value_ff;
   assign rsp_chan.done_res     = done_ff;

   // idle sequencer holds no command
   a_idle_no_cmd: assert property (@(posedge clock) disable iff (reset)
      phase_ff == twrtc_pkg::PH_IDLE |-> command_ff == twrtc_pkg::MODE_TICK)
      else $error("idle with a latched command");

   // last high half of a frame always goes to the end tick
   a_last_bit_end: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == twrtc_pkg::PH_HIGH && bit_count_ff == twrtc_pkg::LAST_BIT
      |=> phase_ff == twrtc_pkg::PH_END)
      else $error("frame did not end after last bit");

   // data line is only released inside a frame, during the read byte
   a_release_in_frame: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> ce_ff && (phase_ff == twrtc_pkg::PH_LOW ||
                              phase_ff == twrtc_pkg::PH_HIGH ||
                              phase_ff == twrtc_pkg::PH_END))
      else $error("data released outside a frame");

   // a finished command leaves the block idle and the bus quiet
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff && !ce_ff && !sclk_ff)
      else $error("done while bus still active");

endmodule

@@ tb/tb_three_wire_rtc_serial_master_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for three_wire_rtc_serial_master_unit: scoreboard class with a
// transaction-exact bus sequencer model, directed command/tick transactions with random noise.
// Depends on twrtc_pkg, twrtc_if and the RTL of the unit.
module tb_three_wire_rtc_serial_master_unit;

   // Run sizing. Each command runs to done: a single register access takes
   // 34 transactions, set time 306 and get time 238; about 620 in all.
   localparam int unsigned LIMIT_CYCLES = 600_000;
   localparam int          DRAIN_CYCLES = 8;

   // One command/tick transaction. set_bytes[0] is seconds ... [6] is year.
   typedef struct packed {
      logic [2:0]      mode;
      logic            data_in;
      logic [7:0]      address;
      logic [7:0]      write_value;
      logic [6:0][7:0] set_bytes;
   } bus_cmd_type;

   // One result transaction: pin levels plus read/done status.
   typedef struct packed {
      logic       ce;
      logic       sclk;
      logic       dout;
      logic       drive;
      logic       busy;
      logic       vvalid;
      logic [2:0] vindex;
      logic [7:0] value;
      logic       done;
   } pin_result_type;

   // How the fake clock chip drives the data line during ticks
   typedef enum {DIN_RANDOM, DIN_LOW, DIN_HIGH} din_style_type;

   // Receiver stall patterns
   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_kind_type;

   // Bus sequencer model plus the queue of predicted pin results.
   class rtc_bus_scoreboard;
      twrtc_pkg::mode_type  cmd;
      twrtc_pkg::phase_type ph;
      logic [3:0]           bit_cnt;
      logic [7:0]           shreg;
      logic [3:0]           frame_idx;
      logic [6:0][7:0]      clk_bytes;
      logic [7:0]           one_addr;
      logic [7:0]           one_val;
      logic                 ce, sclk, dout, drive;
      pin_result_type       expected_pins[$];
      int                   errors;

      function new();
         cmd       = twrtc_pkg::MODE_TICK;
         ph        = twrtc_pkg::PH_IDLE;
         bit_cnt   = '0;
         shreg     = '0;
         frame_idx = '0;
         clk_bytes = '0;
         one_addr  = '0;
         one_val   = '0;
         ce        = 1'b0;
         sclk      = 1'b0;
         dout      = 1'b0;
         drive     = 1'b1;
         errors    = 0;
      endfunction

      function bit busy();
         return ph != twrtc_pkg::PH_IDLE;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      function logic [3:0] frame_count();
         case (cmd)
            twrtc_pkg::MODE_SET: return twrtc_pkg::SET_FRAMES;
            twrtc_pkg::MODE_GET: return twrtc_pkg::GET_FRAMES;
            default:             return twrtc_pkg::SINGLE_FRAMES;
         endcase
      endfunction

      function bit reads_back();
         return cmd == twrtc_pkg::MODE_READ || cmd == twrtc_pkg::MODE_GET;
      endfunction

      // address byte of the current frame
      function logic [7:0] addr_byte();
         int i;
         i = int'(frame_idx);
         if (cmd == twrtc_pkg::MODE_SET) begin
            if (i == 0 || i >= 8) return twrtc_pkg::WP_ADDR;
            return 8'(twrtc_pkg::TIME_WR_BASE + 2 * (i - 1));
         end
         if (cmd == twrtc_pkg::MODE_GET) return 8'(twrtc_pkg::TIME_RD_BASE + 2 * (i & 7));
         return one_addr;
      endfunction

      // data byte of the current write frame
      function logic [7:0] data_byte();
         int i;
         i = int'(frame_idx);
         if (cmd == twrtc_pkg::MODE_SET) begin
            if (i == 0) return twrtc_pkg::WP_CLEAR;
            if (i >= 8) return twrtc_pkg::WP_SET;
            return clk_bytes[(i - 1) % 7];
         end
         return one_val;
      endfunction

      // Advance the model by one accepted transaction and queue its result.
      function void note_request(bus_cmd_type it);
         pin_result_type r;
         logic [7:0]     b;
         r = '0;
         if (ph == twrtc_pkg::PH_IDLE && it.mode >= twrtc_pkg::MODE_WRITE &&
             it.mode <= twrtc_pkg::MODE_GET) begin
            cmd       = twrtc_pkg::mode_type'(it.mode);
            one_addr  = it.address;
            one_val   = it.write_value;
            clk_bytes = it.set_bytes;
            frame_idx = '0;
            ph        = twrtc_pkg::PH_START;
         end
         case (ph)
            twrtc_pkg::PH_START: begin
               ce = 1'b1; sclk = 1'b0; dout = 1'b0; drive = 1'b1;
               bit_cnt = '0;
               shreg   = '0;
               ph      = twrtc_pkg::PH_LOW;
            end
            twrtc_pkg::PH_LOW: begin
               sclk = 1'b0;
               if (bit_cnt >= 8 && reads_back()) begin
                  drive = 1'b0;
                  dout  = 1'b0;
               end else begin
                  b     = (bit_cnt < 8) ? addr_byte() : data_byte();
                  drive = 1'b1;
                  dout  = b[bit_cnt[2:0]];
               end
               ph = twrtc_pkg::PH_HIGH;
            end
            twrtc_pkg::PH_HIGH: begin
               if (bit_cnt >= 8 && reads_back()) shreg = {it.data_in, shreg[7:1]};
               sclk = 1'b1;
               if (bit_cnt >= twrtc_pkg::LAST_BIT) begin
                  ph = twrtc_pkg::PH_END;
               end else begin
                  bit_cnt = bit_cnt + 4'd1;
                  ph      = twrtc_pkg::PH_LOW;
               end
            end
            twrtc_pkg::PH_END: begin
               ce = 1'b0; sclk = 1'b0; dout = 1'b0; drive = 1'b1;
               if (reads_back()) begin
                  r.vvalid = 1'b1;
                  if (cmd == twrtc_pkg::MODE_GET) begin
                     r.vindex = frame_idx[2:0];
                     r.value  = 8'(shreg[7:4] * 10 + shreg[3:0]);
                  end else begin
                     r.vindex = twrtc_pkg::SINGLE_READ_INDEX;
                     r.value  = shreg;
                  end
               end
               frame_idx = frame_idx + 4'd1;
               if (frame_idx >= frame_count()) begin
                  ph     = twrtc_pkg::PH_IDLE;
                  r.done = 1'b1;
                  cmd    = twrtc_pkg::MODE_TICK;
               end else begin
                  ph = twrtc_pkg::PH_START;
               end
            end
            default: ph = twrtc_pkg::PH_IDLE;
         endcase
         r.ce    = ce;
         r.sclk  = sclk;
         r.dout  = dout;
         r.drive = drive;
         r.busy  = ph != twrtc_pkg::PH_IDLE;
         expected_pins.push_back(r);
      endfunction

      function int field_diff(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      function void check_result(pin_result_type got);
         pin_result_type want;
         if (expected_pins.size() == 0) begin
            $display("%0t: result transaction with nothing expected", $time);
            errors++;
            return;
         end
         want = expected_pins.pop_front();
         errors += field_diff("chip_enable", 8'(want.ce), 8'(got.ce));
         errors += field_diff("serial_clock", 8'(want.sclk), 8'(got.sclk));
         errors += field_diff("data_out", 8'(want.dout), 8'(got.dout));
         errors += field_diff("data_drive", 8'(want.drive), 8'(got.drive));
         errors += field_diff("busy_res", 8'(want.busy), 8'(got.busy));
         errors += field_diff("value_valid", 8'(want.vvalid), 8'(got.vvalid));
         errors += field_diff("value_index", 8'(want.vindex), 8'(got.vindex));
         errors += field_diff("read_value", want.value, got.value);
         errors += field_diff("done_res", 8'(want.done), 8'(got.done));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   twrtc_req_if req();
   twrtc_rsp_if rsp();

   three_wire_rtc_serial_master_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #5 clock = ~clock;

   rtc_bus_scoreboard sb;

   // ---------------------------------------------------------------------
   // Sender. Transactions go out in bursts; at the start of each burst the
   // valid line may drop for a random gap. Zero-length gaps give stretches of
   // back-to-back traffic. The model is advanced right here on acceptance, so
   // the stimulus always knows whether the unit is idle.
   // ---------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_item(input bus_cmd_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid       <= 1'b1;
      req.mode        <= it.mode;
      req.data_in     <= it.data_in;
      req.address     <= it.address;
      req.write_value <= it.write_value;
      req.set_seconds <= it.set_bytes[0];
      req.set_minutes <= it.set_bytes[1];
      req.set_hours   <= it.set_bytes[2];
      req.set_date    <= it.set_bytes[3];
      req.set_month   <= it.set_bytes[4];
      req.set_weekday <= it.set_bytes[5];
      req.set_year    <= it.set_bytes[6];
      // ready is sampled as it stood before this edge
      do @(posedge clock); while (!req.ready);
      sb.note_request(it);
   endtask

   function automatic bus_cmd_type random_item();
      bus_cmd_type c;
      c.mode        = 3'($urandom_range(0, 7));
      c.data_in     = 1'($urandom_range(0, 1));
      c.address     = 8'($urandom);
      c.write_value = 8'($urandom);
      c.set_bytes   = 56'({$urandom, $urandom});
      return c;
   endfunction

   function automatic bus_cmd_type make_cmd(twrtc_pkg::mode_type m, logic [7:0] addr,
                                            logic [7:0] val, logic [7:0] fill);
      bus_cmd_type c;
      c             = random_item();
      c.mode        = m;
      c.address     = addr;
      c.write_value = val;
      c.set_bytes   = {7{fill}};
      return c;
   endfunction

   // Start a command while idle and tick it through to done. noise_pct of
   // the ticks carry a nonzero mode with random fields: a command issued
   // while busy must behave as a plain tick.
   task automatic run_command(input bus_cmd_type c, input din_style_type style,
                              input int noise_pct);
      bus_cmd_type t;
      send_item(c);
      while (sb.busy()) begin
         t = random_item();
         if ($urandom_range(1, 100) <= noise_pct) t.mode = 3'($urandom_range(1, 7));
         else t.mode = twrtc_pkg::MODE_TICK;
         case (style)
            DIN_LOW:  t.data_in = 1'b0;
            DIN_HIGH: t.data_in = 1'b1;
            default:  t.data_in = 1'($urandom_range(0, 1));
         endcase
         send_item(t);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver stalls: the pattern switches at random between
   // always ready, random 3-in-4 ready and a fixed 3-of-5 duty cycle.
   // ---------------------------------------------------------------------
   stall_kind_type stall_kind  = STALL_NONE;
   int             stall_left  = 0;
   int unsigned    stall_phase = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind = stall_kind_type'($urandom_range(0, 2));
         stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      stall_phase++;
      case (stall_kind)
         STALL_NONE:   rsp.ready <= 1'b1;
         STALL_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
         default:      rsp.ready <= (stall_phase % 5) >= 2;
      endcase
   end

   // Result monitor: every accepted result transaction is checked in order.
   always @(posedge clock) begin : result_mon
      pin_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.ce     = rsp.chip_enable;
         got.sclk   = rsp.serial_clock;
         got.dout   = rsp.data_out;
         got.drive  = rsp.data_drive;
         got.busy   = rsp.busy_res;
         got.vvalid = rsp.value_valid;
         got.vindex = rsp.value_index;
         got.value  = rsp.read_value;
         got.done   = rsp.done_res;
         sb.check_result(got);
      end
   end

   // Watchdog
   int unsigned cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb_three_wire_rtc_serial_master_unit failed");
         $finish;
      end
   end

   initial begin
      bus_cmd_type c;
      int          k;

      sb = new();
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.mode        <= twrtc_pkg::MODE_TICK;
      req.data_in     <= 1'b0;
      req.address     <= '0;
      req.write_value <= '0;
      req.set_seconds <= '0;
      req.set_minutes <= '0;
      req.set_hours   <= '0;
      req.set_date    <= '0;
      req.set_month   <= '0;
      req.set_weekday <= '0;
      req.set_year    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle tick, then the unused modes while idle: both just tick
      send_item(make_cmd(twrtc_pkg::MODE_TICK, 8'h00, 8'h00, 8'h00));
      c = make_cmd(twrtc_pkg::MODE_TICK, 8'hFF, 8'hFF, 8'hFF);
      for (k = int'(twrtc_pkg::MODE_GET) + 1; k < 8; k++) begin
         c.mode = 3'(k);
         send_item(c);
      end
      // single write with extreme address/data and commands issued while busy
      run_command(make_cmd(twrtc_pkg::MODE_WRITE, 8'hFF, 8'h00, 8'h00), DIN_HIGH, 30);
      // single read returning all ones
      run_command(make_cmd(twrtc_pkg::MODE_READ, 8'h81, 8'h00, 8'h00), DIN_HIGH, 0);
      // set time with every time byte 0xA5
      run_command(make_cmd(twrtc_pkg::MODE_SET, 8'h00, 8'h00, 8'hA5), DIN_RANDOM, 10);
      // get time: random bytes, high nibbles above 9 decode past 99
      run_command(make_cmd(twrtc_pkg::MODE_GET, 8'h00, 8'h00, 8'h00), DIN_RANDOM, 10);
      req.valid <= 1'b0;

      // drain outstanding results, then watch for stray ones
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("tb_three_wire_rtc_serial_master_unit passed");
      end else begin
         $display("tb_three_wire_rtc_serial_master_unit failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/twrtc_pkg.sv
rtl/core/twrtc_if.sv
rtl/core/twrtc_frame_src.sv
rtl/core/three_wire_rtc_serial_master_unit.sv
tb/tb_three_wire_rtc_serial_master_unit.sv
